FILE: src/b64d_pkg.sv
package b64d_pkg;

	localparam logic [7:0] PAD_CHAR   = 8'h3D;
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;
	localparam logic [7:0] SLASH_CHAR = 8'h2F;

	localparam logic [5:0] PLUS_CODE  = 6'd62;
	localparam logic [5:0] SLASH_CODE = 6'd63;

	localparam logic [1:0] GRP_PAD_ONE = 2'd2;
	localparam logic [1:0] GRP_PAD_TWO = 2'd3;
	localparam logic [1:0] GRP_LAST    = 2'd3;

	// One queued run of results: up to three bytes, sent from index 0 upward.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      cnt;
		logic            err;
	} entry_t;

	typedef struct packed {
		logic  push;
		entry_t ent;
	} push_t;

	// Map one character to {valid, code}.
	function automatic logic [6:0] b64_code(input logic [7:0] c);
		logic [6:0] r;
		r = 7'd0;
		if (c >= 8'h41 && c <= 8'h5A)
			r = {1'b1, 6'(c - 8'h41)};
		else if (c >= 8'h61 && c <= 8'h7A)
			r = {1'b1, 6'(c - 8'h61 + 8'd26)};
		else if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 6'(c - 8'h30 + 8'd52)};
		else if (c == PLUS_CHAR)
			r = {1'b1, PLUS_CODE};
		else if (c == SLASH_CHAR)
			r = {1'b1, SLASH_CODE};
		return r;
	endfunction

endpackage

FILE: src/b64d_front.sv
module b64d_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      in_char,
	input  logic            end_of_text,
	output b64d_pkg::push_t push
);
	import b64d_pkg::*;

	logic [23:0] acc_q;
	logic [1:0]  grp_q;
	logic        stopped_q;

	logic [23:0] acc_d;
	logic [1:0]  grp_d;
	logic        stopped_d;
	logic [6:0]  lut;
	logic [23:0] acc_shift;

	assign lut       = b64_code(in_char);
	assign acc_shift = {acc_q[17:0], lut[5:0]};

	always_comb begin
		acc_d     = acc_q;
		grp_d     = grp_q;
		stopped_d = stopped_q;
		push      = '0;
		if (take && !stopped_q) begin
			if (in_char == PAD_CHAR) begin
				stopped_d = 1'b1;
				if (grp_q == GRP_PAD_ONE) begin
					push.push      = 1'b1;
					push.ent.bytes = {8'd0, 8'd0, acc_q[11:4]};
					push.ent.cnt   = 2'd1;
				end else if (grp_q == GRP_PAD_TWO) begin
					push.push      = 1'b1;
					push.ent.bytes = {8'd0, acc_q[9:2], acc_q[17:10]};
					push.ent.cnt   = 2'd2;
				end
			end else if (!lut[6]) begin
				stopped_d     = 1'b1;
				push.push     = 1'b1;
				push.ent.cnt  = 2'd1;
				push.ent.err  = 1'b1;
			end else begin
				acc_d = acc_shift;
				grp_d = grp_q + 2'd1;
				if (grp_q == GRP_LAST) begin
					push.push      = 1'b1;
					push.ent.bytes = {acc_shift[7:0], acc_shift[15:8], acc_shift[23:16]};
					push.ent.cnt   = 2'd3;
				end
			end
		end
		if (take && end_of_text) begin
			acc_d     = '0;
			grp_d     = '0;
			stopped_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			grp_q     <= '0;
			stopped_q <= 1'b0;
		end else begin
			acc_q     <= acc_d;
			grp_q     <= grp_d;
			stopped_q <= stopped_d;
		end
	end

endmodule

FILE: src/b64d_fifo.sv
module b64d_fifo #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  b64d_pkg::push_t  push,
	input  logic             pop,
	output b64d_pkg::entry_t head,
	output logic             empty,
	output logic             full
);
	import b64d_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == FULL_CNT);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push.push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push.ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

FILE: src/b64d_back.sv
module b64d_back (
	input  logic             clk,
	input  logic             arst_n,
	input  b64d_pkg::entry_t head,
	input  logic             empty,
	output logic             pop,
	output logic             byte_valid,
	input  logic             byte_stall,
	output logic [7:0]       out_byte,
	output logic             invalid_char,
	output logic             run_last
);
	import b64d_pkg::*;

	entry_t     ent_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       sent;

	assign byte_valid   = busy_q;
	assign out_byte     = ent_q.bytes[idx_q];
	assign invalid_char = ent_q.err;
	assign run_last     = (idx_q == ent_q.cnt - 2'd1);
	assign sent         = busy_q && !byte_stall;
	assign pop          = !empty && (!busy_q || (sent && run_last));

	always_ff @(posedge clk) begin
		if (pop)
			ent_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			busy_q <= 1'b0;
		end else begin
			if (pop) begin
				idx_q  <= '0;
				busy_q <= 1'b1;
			end else if (sent) begin
				if (run_last)
					busy_q <= 1'b0;
				else
					idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

FILE: src/base64_stream_decoder.sv
// Each run passes through the run queue and then the back stage's run register.
// Throughput: one character per cycle in, one byte per cycle out while byte_stall
// is low; a full group of four characters yields three bytes; output keeps pace.
// Input stalls only when the FIFO_DEPTH-entry run queue is full.
// Reset (arst_n low, asynchronous) clears decoder state, queue and output valid.
module base64_stream_decoder #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] in_char,
	input  logic       end_of_text,
	output logic       byte_valid,
	input  logic       byte_stall,
	output logic [7:0] out_byte,
	output logic       invalid_char,
	output logic       run_last
);
	import b64d_pkg::*;

	push_t  push;
	entry_t head;
	logic   empty;
	logic   full;
	logic   pop;
	logic   take;

	// Hold the input word whenever the queue has no room for a run.
	assign char_stall = full;
	assign take       = char_valid && !full;

	// Front: decode the character, track the group, queue one run of results.
	b64d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.in_char     (in_char),
		.end_of_text (end_of_text),
		.push        (push)
	);

	// Queue: decouple character intake from byte delivery.
	b64d_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.full   (full)
	);

	// Back: advance through each run one byte per delivered word.
	b64d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.out_byte     (out_byte),
		.invalid_char (invalid_char),
		.run_last     (run_last)
	);

endmodule
